/* rtl/sfc_pkg.sv */
// ----------------------------------------------------------------------------
// sfc_pkg
// shared widths, codes and pipeline control types for the sphere frustum cull
// ----------------------------------------------------------------------------
`default_nettype none

package sfc_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 14;

    // packed register fields are fixed at 16 bits, clip depths at 32 bits
    localparam int COEF_BITS  = 16;
    localparam int CLIP_BITS  = 32;
    localparam int CFG_BITS   = 64;
    localparam int RAD_BITS   = 15;

    // world-to-view transform
    localparam int PROD_BITS  = COORD_BITS + COEF_BITS;
    localparam int SUM_BITS   = PROD_BITS + 2;
    localparam int VIEW_BITS  = ((SUM_BITS - FRAC_BITS) > COEF_BITS ?
                                 (SUM_BITS - FRAC_BITS) : COEF_BITS) + 1;

    // plane distances
    localparam int PP_BITS    = VIEW_BITS + COEF_BITS;
    localparam int DIST_BITS  = PP_BITS + 1;
    localparam int RF_BITS    = RAD_BITS + FRAC_BITS;
    localparam int CMP_BITS   = (DIST_BITS > RF_BITS + 1 ? DIST_BITS : RF_BITS + 1) + 1;

    // depth compares
    localparam int DEPTH_BITS = (VIEW_BITS > CLIP_BITS ? VIEW_BITS : CLIP_BITS) + 2;

    // configuration register indexes
    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_VIEW_ROW_X   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_VIEW_ROW_Y   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_VIEW_ROW_Z   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HORIZ_PLANES = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_VERT_PLANES  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_DEPTHS  = 3'd5;

    // location codes
    localparam int LOC_BITS = 2;
    localparam logic [LOC_BITS-1:0] LOC_INSIDE  = 2'd0;
    localparam logic [LOC_BITS-1:0] LOC_BOUND   = 2'd1;
    localparam logic [LOC_BITS-1:0] LOC_OUTSIDE = 2'd2;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } sfc_pipe_en_t;

    typedef struct packed {
        logic signed [VIEW_BITS-1:0] vx;
        logic signed [VIEW_BITS-1:0] vy;
        logic signed [VIEW_BITS-1:0] vz;
        logic [RAD_BITS-1:0]         radius;
        logic                        test_back;
        logic                        test_vertical;
    } sfc_view_t;

endpackage

`default_nettype wire

/* rtl/sfc_view_xform.sv */
// ----------------------------------------------------------------------------
// sfc_view_xform
// two-stage world-to-view transform: nine products, then row sums, translation after the shift
// ----------------------------------------------------------------------------
`default_nettype none

module sfc_view_xform
    import sfc_pkg::*;
(
    input  wire logic                         clk,
    input  wire sfc_pipe_en_t                 en,
    input  wire logic [CFG_BITS-1:0]          view_row_x,
    input  wire logic [CFG_BITS-1:0]          view_row_y,
    input  wire logic [CFG_BITS-1:0]          view_row_z,
    input  wire logic signed [COORD_BITS-1:0] centre_x,
    input  wire logic signed [COORD_BITS-1:0] centre_y,
    input  wire logic signed [COORD_BITS-1:0] centre_z,
    input  wire logic [RAD_BITS-1:0]          radius,
    input  wire logic                         test_back,
    input  wire logic                         test_vertical,
    output sfc_view_t                         view
);

    logic signed [PROD_BITS-1:0] prod_reg [3][3];
    logic signed [PROD_BITS-1:0] prod_next [3][3];
    logic [RAD_BITS-1:0]         r1_reg;
    logic                        tb1_reg;
    logic                        tv1_reg;
    logic signed [VIEW_BITS-1:0] vc_next [3];
    sfc_view_t                   view_reg;
    sfc_view_t                   view_next;
    logic [CFG_BITS-1:0]         rows [3];

    assign rows[0] = view_row_x;
    assign rows[1] = view_row_y;
    assign rows[2] = view_row_z;

    // stage 1: one product per rotation term
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod_next[i][0] = PROD_BITS'($signed(rows[i][15:0])  * centre_x);
            prod_next[i][1] = PROD_BITS'($signed(rows[i][31:16]) * centre_y);
            prod_next[i][2] = PROD_BITS'($signed(rows[i][47:32]) * centre_z);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            prod_reg <= prod_next;
            r1_reg   <= radius;
            tb1_reg  <= test_back;
            tv1_reg  <= test_vertical;
        end
    end

    // stage 2: sum, floor shift, translation
    always_comb
    begin
        logic signed [SUM_BITS-1:0] sum;
        logic signed [SUM_BITS-1:0] shifted;
        for (int i = 0; i < 3; i++)
        begin
            sum = SUM_BITS'(prod_reg[i][0]) + SUM_BITS'(prod_reg[i][1])
                + SUM_BITS'(prod_reg[i][2]);
            shifted = sum >>> FRAC_BITS;
            vc_next[i] = VIEW_BITS'(shifted) + VIEW_BITS'($signed(rows[i][63:48]));
        end
        view_next.vx            = vc_next[0];
        view_next.vy            = vc_next[1];
        view_next.vz            = vc_next[2];
        view_next.radius        = r1_reg;
        view_next.test_back     = tb1_reg;
        view_next.test_vertical = tv1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            view_reg <= view_next;
        end
    end

    assign view = view_reg;

endmodule

`default_nettype wire

/* rtl/sfc_plane_test.sv */
// ----------------------------------------------------------------------------
// sfc_plane_test
// two-stage classification: depth compares and plane products, then plane
// distances against the scaled radius and the final location
// ----------------------------------------------------------------------------
`default_nettype none

module sfc_plane_test
    import sfc_pkg::*;
(
    input  wire logic                 clk,
    input  wire sfc_pipe_en_t         en,
    input  wire logic [CFG_BITS-1:0]  horizontal_planes,
    input  wire logic [CFG_BITS-1:0]  vertical_planes,
    input  wire logic [CFG_BITS-1:0]  clip_depths,
    input  wire sfc_view_t            view,
    output logic [LOC_BITS-1:0]       location
);

    // products: left x, left z, right x, right z, top y, top z, bottom y, bottom z
    logic signed [PP_BITS-1:0] pp_reg [8];
    logic signed [PP_BITS-1:0] pp_next [8];
    logic                      d_out_reg;
    logic                      d_out_next;
    logic                      d_bnd_reg;
    logic                      d_bnd_next;
    logic [RAD_BITS-1:0]       r3_reg;
    logic                      tv3_reg;
    logic [LOC_BITS-1:0]       loc_reg;
    logic [LOC_BITS-1:0]       loc_next;

    // stage 3
    always_comb
    begin
        logic signed [DEPTH_BITS-1:0] vz_e;
        logic signed [DEPTH_BITS-1:0] r_e;
        logic signed [DEPTH_BITS-1:0] front;
        logic signed [DEPTH_BITS-1:0] back;
        logic                         f_out;
        logic                         f_bnd;
        logic                         b_out;
        logic                         b_bnd;

        pp_next[0] = PP_BITS'(view.vx * $signed(horizontal_planes[15:0]));
        pp_next[1] = PP_BITS'(view.vz * $signed(horizontal_planes[31:16]));
        pp_next[2] = PP_BITS'(view.vx * $signed(horizontal_planes[47:32]));
        pp_next[3] = PP_BITS'(view.vz * $signed(horizontal_planes[63:48]));
        pp_next[4] = PP_BITS'(view.vy * $signed(vertical_planes[15:0]));
        pp_next[5] = PP_BITS'(view.vz * $signed(vertical_planes[31:16]));
        pp_next[6] = PP_BITS'(view.vy * $signed(vertical_planes[47:32]));
        pp_next[7] = PP_BITS'(view.vz * $signed(vertical_planes[63:48]));

        vz_e  = DEPTH_BITS'(view.vz);
        r_e   = DEPTH_BITS'($signed({1'b0, view.radius}));
        front = DEPTH_BITS'($signed(clip_depths[CLIP_BITS-1:0]));
        back  = DEPTH_BITS'($signed(clip_depths[2*CLIP_BITS-1:CLIP_BITS]));

        f_out = (vz_e + r_e) < front;
        f_bnd = !f_out && ((vz_e - r_e) < front);
        b_out = view.test_back && ((vz_e - r_e) > back);
        b_bnd = view.test_back && !b_out && ((vz_e + r_e) > back);

        d_out_next = f_out || b_out;
        d_bnd_next = f_bnd || b_bnd;
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            pp_reg    <= pp_next;
            d_out_reg <= d_out_next;
            d_bnd_reg <= d_bnd_next;
            r3_reg    <= view.radius;
            tv3_reg   <= view.test_vertical;
        end
    end

    // stage 4
    always_comb
    begin
        logic signed [CMP_BITS-1:0] rf;
        logic signed [CMP_BITS-1:0] plane_dist;
        logic                       any_out;
        logic                       any_bnd;
        logic                       p_out;

        rf      = CMP_BITS'($signed({1'b0, r3_reg})) <<< FRAC_BITS;
        any_out = d_out_reg;
        any_bnd = d_bnd_reg;
        for (int p = 0; p < 4; p++)
        begin
            plane_dist = CMP_BITS'(DIST_BITS'(pp_reg[2*p]) + DIST_BITS'(pp_reg[2*p+1]));
            p_out      = plane_dist > rf;
            // top and bottom planes only count in the 3d check
            if (p < 2 || tv3_reg)
            begin
                any_out = any_out || p_out;
                any_bnd = any_bnd || (!p_out && (plane_dist > -rf));
            end
        end

        priority if (any_out)
        begin
            loc_next = LOC_OUTSIDE;
        end
        else if (any_bnd)
        begin
            loc_next = LOC_BOUND;
        end
        else
        begin
            loc_next = LOC_INSIDE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            loc_reg <= loc_next;
        end
    end

    assign location = loc_reg;

endmodule

`default_nettype wire

/* rtl/sphere_frustum_cull.sv */
// ----------------------------------------------------------------------------
// sphere_frustum_cull
// sphere-versus-view-frustum classifier, four-stage pipeline
// ----------------------------------------------------------------------------
// Takes one sphere request per clock while in_stall is low and returns one
// location per request, in order, through the four register stages below.
// The four register stages (centre products, view transform, plane products
// with depth compares, plane distances with final classification) each take
// a new request whenever the stage after them moves on, so bubbles close up
// and in_stall rises only when all four stages hold a request and the output
// is stalled. Configuration writes are always taken (cfg_ready is high) and
// must only be issued while no request is in flight.
`default_nettype none

module sphere_frustum_cull
    import sfc_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,

    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]      cfg_index,
    input  wire logic [CFG_BITS-1:0]          cfg_data,

    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic signed [COORD_BITS-1:0] centre_x,
    input  wire logic signed [COORD_BITS-1:0] centre_y,
    input  wire logic signed [COORD_BITS-1:0] centre_z,
    input  wire logic [RAD_BITS-1:0]          radius,
    input  wire logic                         test_back,
    input  wire logic                         test_vertical,

    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [LOC_BITS-1:0]               location
);

    logic [CFG_BITS-1:0] view_row_x_reg;
    logic [CFG_BITS-1:0] view_row_y_reg;
    logic [CFG_BITS-1:0] view_row_z_reg;
    logic [CFG_BITS-1:0] horiz_reg;
    logic [CFG_BITS-1:0] vert_reg;
    logic [CFG_BITS-1:0] clip_reg;

    logic         v1_reg;
    logic         v2_reg;
    logic         v3_reg;
    logic         v4_reg;
    logic         v1_next;
    logic         v2_next;
    logic         v3_next;
    logic         v4_next;
    sfc_pipe_en_t en;
    sfc_view_t    view;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_row_x_reg <= '0;
            view_row_y_reg <= '0;
            view_row_z_reg <= '0;
            horiz_reg      <= '0;
            vert_reg       <= '0;
            clip_reg       <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_VIEW_ROW_X:   view_row_x_reg <= cfg_data;
                CFG_VIEW_ROW_Y:   view_row_y_reg <= cfg_data;
                CFG_VIEW_ROW_Z:   view_row_z_reg <= cfg_data;
                CFG_HORIZ_PLANES: horiz_reg      <= cfg_data;
                CFG_VERT_PLANES:  vert_reg       <= cfg_data;
                CFG_CLIP_DEPTHS:  clip_reg       <= cfg_data;
                default:          ;
            endcase
        end
    end

    // a stage loads when it is empty or its contents move on
    always_comb
    begin
        en.s4    = !v4_reg || !out_stall;
        en.s3    = !v3_reg || en.s4;
        en.s2    = !v2_reg || en.s3;
        en.s1    = !v1_reg || en.s2;
        in_stall = !en.s1;

        v1_next = en.s1 ? in_valid : v1_reg;
        v2_next = en.s2 ? v1_reg   : v2_reg;
        v3_next = en.s3 ? v2_reg   : v3_reg;
        v4_next = en.s4 ? v3_reg   : v4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    assign out_valid = v4_reg;

    sfc_view_xform u_xform (
        .clk           (clk),
        .en            (en),
        .view_row_x    (view_row_x_reg),
        .view_row_y    (view_row_y_reg),
        .view_row_z    (view_row_z_reg),
        .centre_x      (centre_x),
        .centre_y      (centre_y),
        .centre_z      (centre_z),
        .radius        (radius),
        .test_back     (test_back),
        .test_vertical (test_vertical),
        .view          (view)
    );

    sfc_plane_test u_plane (
        .clk               (clk),
        .en                (en),
        .horizontal_planes (horiz_reg),
        .vertical_planes   (vert_reg),
        .clip_depths       (clip_reg),
        .view              (view),
        .location          (location)
    );

    // the value 3 is never a location
    a_loc_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (location == LOC_INSIDE || location == LOC_BOUND ||
                       location == LOC_OUTSIDE))
        else $error("invalid location code");

    // back-pressure only with a full pipeline and a stalled output
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (v1_reg && v2_reg && v3_reg && v4_reg && out_stall))
        else $error("input stalled with room in the pipeline");

    // an accepted request lands in the first stage
    a_accept_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> v1_reg)
        else $error("accepted request lost at stage 1");

    // a full stage 3 with a free output hands on its request
    a_s3_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !(v4_reg && out_stall)) |=> v4_reg)
        else $error("request lost between stage 3 and output");

endmodule

`default_nettype wire
